>>> rtl/core/asbce_pkg.sv
// ----------------------------------------------------------------------------
// asbce_pkg: shared types for the alpha search by compositing error
// Request and response payloads and the control bits that travel with each
// pixel through the step pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package asbce_pkg;

    // Widths of the fixed payload fields
    localparam int COLOR_IN_W = 8;
    localparam int STEP_OUT_W = 7;
    localparam int ERR_OUT_W  = 17;

    // Saturation limits of the response fields
    localparam int STEP_SAT = 127;
    localparam int ERR_SAT  = 131071;

    // One pixel request: observed, foreground and background colors
    typedef struct packed {
        logic [COLOR_IN_W-1:0] pixel_red;
        logic [COLOR_IN_W-1:0] pixel_green;
        logic [COLOR_IN_W-1:0] pixel_blue;
        logic [COLOR_IN_W-1:0] fore_red;
        logic [COLOR_IN_W-1:0] fore_green;
        logic [COLOR_IN_W-1:0] fore_blue;
        logic [COLOR_IN_W-1:0] back_red;
        logic [COLOR_IN_W-1:0] back_green;
        logic [COLOR_IN_W-1:0] back_blue;
        logic                  has_two_layers;
    } t_pixel_req;

    // One response: best alpha step and its score
    typedef struct packed {
        logic [STEP_OUT_W-1:0] alpha_step;
        logic [ERR_OUT_W-1:0]  best_error;
        logic                  updated;
    } t_alpha_rsp;

    // Control bits that ride along with each pipeline stage
    typedef struct packed {
        logic valid;
        logic two_layers;
    } t_step_ctl;

endpackage

`default_nettype wire

>>> rtl/core/asbce_step.sv
// ----------------------------------------------------------------------------
// asbce_step: one alpha step of the search pipeline
// Scores the incoming per-channel compositing residuals at this step, keeps
// the running best, and advances each residual to the next step.
// ----------------------------------------------------------------------------
`default_nettype none

module asbce_step #(
    parameter int STEP = 0,
    parameter int K_W  = 7,
    parameter int D_W  = 9,
    parameter int V_W  = 17,
    parameter int S_W  = 19
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire asbce_pkg::t_step_ctl   i_ctl,
    input  wire logic signed [V_W-1:0]  i_v [3],
    input  wire logic signed [D_W-1:0]  i_d [3],
    input  wire logic        [S_W-1:0]  i_best,
    input  wire logic        [K_W-1:0]  i_k,
    output asbce_pkg::t_step_ctl        o_ctl,
    output logic signed      [V_W-1:0]  o_v [3],
    output logic signed      [D_W-1:0]  o_d [3],
    output logic             [S_W-1:0]  o_best,
    output logic             [K_W-1:0]  o_k
);

    asbce_pkg::t_step_ctl   r_ctl;
    logic signed [V_W-1:0]  r_v [3];
    logic signed [D_W-1:0]  r_d [3];
    logic        [S_W-1:0]  r_best;
    logic        [K_W-1:0]  r_k;

    logic        [V_W-2:0]  mag [3];
    logic        [S_W-1:0]  score;
    logic                   take;

    // Score this step: sum of absolute residuals, strict compare keeps lowest k
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mag[c] = i_v[c][V_W-1] ? (V_W-1)'(-i_v[c]) : (V_W-1)'(i_v[c]);
        end
        score = S_W'(mag[0]) + S_W'(mag[1]) + S_W'(mag[2]);
        take  = (STEP == 0) || (score < i_best);
    end

    // Advance the valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    // Advance the payload and step each residual by F - B
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 3; c++) begin
                r_v[c] <= i_v[c] + V_W'(i_d[c]);
                r_d[c] <= i_d[c];
            end
            r_best <= take ? score : i_best;
            r_k    <= take ? K_W'(STEP) : i_k;
        end
    end

    assign o_ctl  = r_ctl;
    assign o_v    = r_v;
    assign o_d    = r_d;
    assign o_best = r_best;
    assign o_k    = r_k;

endmodule

`default_nettype wire

>>> rtl/core/alpha_search_by_compositing_error.sv
// ----------------------------------------------------------------------------
// alpha_search_by_compositing_error: per-pixel alpha fit
// Finds the alpha step k in 0..ALPHA_STEPS minimizing the summed absolute
// compositing error |k*F + (N-k)*B - N*C| over the three color channels.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_req_valid / o_req_ready / i_req) carries one pixel:
//   observed, foreground and background colors plus the two-layer flag.
//   Response channel (o_rsp_valid / i_rsp_ready / o_rsp) returns one result
//   per request, in request order: best step, its error and the updated flag.
//   Single-layer pixels come back with all response fields zero.
//   The pipeline has an input stage, loaded at the accepting edge, one register
//   stage per alpha step k = 0..ALPHA_STEPS, and an output stage.
//   Throughput: one pixel per cycle while the skid register is empty.
//   An output skid register holds a response that the receiver stalls on;
//   while it is full the whole pipeline freezes and o_req_ready is low.
//   o_req_ready is a register output with no path from i_rsp_ready.
//   Reset clears all valid bits; there is no other state to initialize.
// ----------------------------------------------------------------------------
`default_nettype none

module alpha_search_by_compositing_error #(
    parameter int ALPHA_STEPS = 100,
    parameter int COLOR_BITS  = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_ready,
    input  wire asbce_pkg::t_pixel_req i_req,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_ready,
    output asbce_pkg::t_alpha_rsp  o_rsp
);

    localparam int MAX_C = (1 << COLOR_BITS) - 1;
    localparam int V_MAX = ALPHA_STEPS * MAX_C;
    localparam int V_W   = $clog2(V_MAX + 1) + 1;
    localparam int S_W   = $clog2(3 * V_MAX + 1);
    localparam int K_W   = $clog2(ALPHA_STEPS + 1);
    localparam int D_W   = COLOR_BITS + 1;
    localparam int IN_W  = (COLOR_BITS > asbce_pkg::COLOR_IN_W) ?
                           COLOR_BITS : asbce_pkg::COLOR_IN_W;
    localparam int NSTG  = ALPHA_STEPS + 2;
    localparam int EX_W  = (S_W > asbce_pkg::ERR_OUT_W) ? S_W : asbce_pkg::ERR_OUT_W;
    localparam int KX_W  = (K_W > asbce_pkg::STEP_OUT_W) ? K_W : asbce_pkg::STEP_OUT_W;
    localparam logic signed [V_W-1:0] N_S = V_W'(ALPHA_STEPS);

    logic                   en;

    // Input stage
    logic        [IN_W-1:0]       c_wide [3];
    logic        [IN_W-1:0]       f_wide [3];
    logic        [IN_W-1:0]       b_wide [3];
    logic        [COLOR_BITS-1:0] c_col [3];
    logic        [COLOR_BITS-1:0] f_col [3];
    logic        [COLOR_BITS-1:0] b_col [3];
    logic signed [D_W-1:0]        diff_bc [3];
    logic signed [D_W-1:0]        diff_fb [3];
    asbce_pkg::t_step_ctl         r_pre_ctl;
    logic signed [V_W-1:0]        r_pre_v [3];
    logic signed [D_W-1:0]        r_pre_d [3];

    // Step pipeline links
    asbce_pkg::t_step_ctl   s_ctl  [NSTG];
    logic signed [V_W-1:0]  s_v    [NSTG][3];
    logic signed [D_W-1:0]  s_d    [NSTG][3];
    logic        [S_W-1:0]  s_best [NSTG];
    logic        [K_W-1:0]  s_k    [NSTG];

    // Output stage and skid
    logic        [EX_W-1:0] best_ext;
    logic        [KX_W-1:0] k_ext;
    asbce_pkg::t_alpha_rsp  n_res;
    asbce_pkg::t_alpha_rsp  r_res;
    logic                   r_res_valid;
    asbce_pkg::t_alpha_rsp  r_skid;
    logic                   r_skid_valid;

    // Advance the whole pipeline whenever the skid register is free
    assign en          = !r_skid_valid;
    assign o_req_ready = en;

    // Take each color in its low COLOR_BITS bits and form the residual seeds
    always_comb begin
        c_wide[0] = IN_W'(i_req.pixel_red);
        c_wide[1] = IN_W'(i_req.pixel_green);
        c_wide[2] = IN_W'(i_req.pixel_blue);
        f_wide[0] = IN_W'(i_req.fore_red);
        f_wide[1] = IN_W'(i_req.fore_green);
        f_wide[2] = IN_W'(i_req.fore_blue);
        b_wide[0] = IN_W'(i_req.back_red);
        b_wide[1] = IN_W'(i_req.back_green);
        b_wide[2] = IN_W'(i_req.back_blue);
        for (int c = 0; c < 3; c++) begin
            c_col[c]   = c_wide[c][COLOR_BITS-1:0];
            f_col[c]   = f_wide[c][COLOR_BITS-1:0];
            b_col[c]   = b_wide[c][COLOR_BITS-1:0];
            diff_bc[c] = signed'({1'b0, b_col[c]}) - signed'({1'b0, c_col[c]});
            diff_fb[c] = signed'({1'b0, f_col[c]}) - signed'({1'b0, b_col[c]});
        end
    end

    // Input stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_ctl <= '0;
        end else if (en) begin
            r_pre_ctl.valid      <= i_req_valid;
            r_pre_ctl.two_layers <= i_req.has_two_layers;
        end
    end

    // Input stage payload: residual at k = 0 is N*(B - C)
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                r_pre_v[c] <= V_W'(diff_bc[c]) * N_S;
                r_pre_d[c] <= diff_fb[c];
            end
        end
    end

    assign s_ctl[0]  = r_pre_ctl;
    assign s_v[0]    = r_pre_v;
    assign s_d[0]    = r_pre_d;
    assign s_best[0] = '0;
    assign s_k[0]    = '0;

    // One stage per alpha step
    for (genvar g = 0; g <= ALPHA_STEPS; g++) begin : g_step
        asbce_step #(
            .STEP (g),
            .K_W  (K_W),
            .D_W  (D_W),
            .V_W  (V_W),
            .S_W  (S_W)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (s_ctl[g]),
            .i_v     (s_v[g]),
            .i_d     (s_d[g]),
            .i_best  (s_best[g]),
            .i_k     (s_k[g]),
            .o_ctl   (s_ctl[g+1]),
            .o_v     (s_v[g+1]),
            .o_d     (s_d[g+1]),
            .o_best  (s_best[g+1]),
            .o_k     (s_k[g+1])
        );
    end

    // Saturate into the response fields; zero them for single-layer pixels
    always_comb begin
        best_ext = EX_W'(s_best[NSTG-1]);
        k_ext    = KX_W'(s_k[NSTG-1]);
        n_res    = '0;
        if (s_ctl[NSTG-1].two_layers) begin
            n_res.alpha_step = (k_ext > KX_W'(asbce_pkg::STEP_SAT)) ?
                               asbce_pkg::STEP_OUT_W'(asbce_pkg::STEP_SAT) :
                               k_ext[asbce_pkg::STEP_OUT_W-1:0];
            n_res.best_error = (best_ext > EX_W'(asbce_pkg::ERR_SAT)) ?
                               asbce_pkg::ERR_OUT_W'(asbce_pkg::ERR_SAT) :
                               best_ext[asbce_pkg::ERR_OUT_W-1:0];
            n_res.updated    = 1'b1;
        end
    end

    // Output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (en) begin
            r_res_valid <= s_ctl[NSTG-1].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_res <= n_res;
        end
    end

    // Catch a stalled response in the skid register; drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (i_rsp_ready) begin
                r_skid_valid <= 1'b0;
            end
        end else if (r_res_valid && !i_rsp_ready) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            r_skid <= r_res;
        end
    end

    assign o_rsp_valid = r_skid_valid || r_res_valid;
    assign o_rsp       = r_skid_valid ? r_skid : r_res;

`ifndef SYNTHESIS
    // A full skid register freezes the output stage
    a_skid_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_skid_valid) |=> ($stable(r_res_valid) && $stable(r_res)))
        else $error("output stage moved while skid register was full");

    // Single-layer responses carry no alpha and no error
    a_single_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && !o_rsp.updated) |->
        (o_rsp.alpha_step == '0 && o_rsp.best_error == '0))
        else $error("single-layer response with nonzero fields");

    // The chosen step never exceeds the search range
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && o_rsp.updated) |->
        (int'(o_rsp.alpha_step) <= ALPHA_STEPS))
        else $error("alpha step beyond search range");
`endif

endmodule

`default_nettype wire
